@@ rtl/line_of_sight_occlusion_test_assert.svh @@
// Assertion macros for the line-of-sight occlusion test block.
`ifndef LINE_OF_SIGHT_OCCLUSION_TEST_ASSERT_SVH
`define LINE_OF_SIGHT_OCCLUSION_TEST_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LOST_ASSERT_HOLD(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lost assertion failed");
// next-cycle implication
`define LOST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lost assertion failed");
`else
`define LOST_ASSERT_HOLD(lbl, clk, rstn, ante, cons)
`define LOST_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/lost_pkg.sv @@
// Shared constants and types of the line-of-sight occlusion test block.
`default_nettype none
package lost_pkg;
    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_WIDTH_DEF  = 16;
    localparam int FIELD_W          = 16;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    // which cross product the multiply-subtract unit forms
    typedef enum logic [1:0] {
        OP_DEN = 2'd0,
        OP_NA  = 2'd1,
        OP_NB  = 2'd2
    } musub_op_t;

    typedef struct packed {
        logic      en;
        musub_op_t op;
    } musub_ctrl_t;
endpackage
`default_nettype wire

@@ rtl/lost_musub.sv @@
// Shared multiply-subtract unit: one cross product a*b - c*d per pass, registered.
`default_nettype none
module lost_musub #(
    parameter int W = 17
) (
    input  wire logic                   aclk,
    input  wire lost_pkg::musub_ctrl_t  ctrl,
    input  wire logic signed [W-1:0]    dxs,
    input  wire logic signed [W-1:0]    dys,
    input  wire logic signed [W-1:0]    dxw,
    input  wire logic signed [W-1:0]    dyw,
    input  wire logic signed [W-1:0]    ox,
    input  wire logic signed [W-1:0]    oy,
    output logic signed [2*W:0]         res
);
    import lost_pkg::*;

    logic signed [W-1:0]   opa, opb, opc, opd;
    logic signed [2*W-1:0] p_ab, p_cd;
    logic signed [2*W:0]   diff;
    logic signed [2*W:0]   res_reg;

    always_comb begin
        case (ctrl.op)
            OP_DEN: begin
                opa = dyw; opb = dxs; opc = dxw; opd = dys;
            end
            OP_NA: begin
                opa = dxw; opb = oy;  opc = dyw; opd = ox;
            end
            OP_NB: begin
                opa = dxs; opb = oy;  opc = dys; opd = ox;
            end
            default: begin
                opa = '0; opb = '0; opc = '0; opd = '0;
            end
        endcase
    end

    assign p_ab = opa * opb;
    assign p_cd = opc * opd;
    assign diff = {p_ab[2*W-1], p_ab} - {p_cd[2*W-1], p_cd};

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            res_reg <= diff;
        end
    end

    assign res = res_reg;
endmodule
`default_nettype wire

@@ rtl/lost_vstore.sv @@
// Wall vertex memory: one write port, one registered read port.
`default_nettype none
module lost_vstore #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 33
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [DW-1:0]      rd_data
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

@@ rtl/line_of_sight_occlusion_test.sv @@
// Top level of the line-of-sight occlusion test: sequencer, wall store and edge test.
`default_nettype none
`include "line_of_sight_occlusion_test_assert.svh"
// Clear and append words give no result; a full store drops further vertices and sets
// the overflow flag until the next clear. A query walks the stored vertices in order, one
// wall edge at a time, with the last open polygon closed back to its first vertex. Each
// edge needs a memory read (except the closing edge after the last vertex) and three
// passes through the single multiply-subtract unit plus a compare, and a query ends
// early when an edge blocks. s_ready is high only between queries, but a finished
// result may sit in the output register while new words are taken.
module line_of_sight_occlusion_test #(
    parameter int MAX_VERTICES = lost_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = lost_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_action,
    input  wire logic [lost_pkg::FIELD_W-1:0]  s_vertex_x,
    input  wire logic [lost_pkg::FIELD_W-1:0]  s_vertex_y,
    input  wire logic                          s_closes_polygon,
    input  wire logic [lost_pkg::FIELD_W-1:0]  s_viewer_id,
    input  wire logic [lost_pkg::FIELD_W-1:0]  s_viewer_x,
    input  wire logic [lost_pkg::FIELD_W-1:0]  s_viewer_y,
    input  wire logic [lost_pkg::FIELD_W-1:0]  s_target_x,
    input  wire logic [lost_pkg::FIELD_W-1:0]  s_target_y,
    input  wire logic                          s_last_query,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [lost_pkg::FIELD_W-1:0]       m_result_id,
    output logic                               m_can_see,
    output logic                               m_store_overflowed,
    output logic                               m_last_in_batch
);
    import lost_pkg::*;

    localparam int CW   = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
    localparam int W    = CW + 1;
    localparam int PW   = 2 * W + 1;
    localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int VW   = 2 * CW + 1;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_FETCH = 10'b00_0000_0010,
        ST_LOAD  = 10'b00_0000_0100,
        ST_TAIL  = 10'b00_0000_1000,
        ST_E0    = 10'b00_0001_0000,
        ST_E1    = 10'b00_0010_0000,
        ST_E2    = 10'b00_0100_0000,
        ST_E3    = 10'b00_1000_0000,
        ST_DONE  = 10'b01_0000_0000
    } state_t;

    function automatic logic signed [W-1:0] sx(input logic [CW-1:0] v);
        return {v[CW-1], v};
    endfunction

    // num/den within [0,1], den nonzero
    function automatic logic in_unit(input logic signed [PW-1:0] num,
                                     input logic signed [PW-1:0] den);
        logic num_ge0, num_le0;
        num_ge0 = !num[PW-1];
        num_le0 = num[PW-1] || (num == '0);
        if (!den[PW-1]) begin
            return num_ge0 && (num <= den);
        end else begin
            return num_le0 && (num >= den);
        end
    endfunction

    // control state
    state_t            state_reg, state_next;
    logic [CNTW-1:0]   count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CNTW-1:0]   idx_reg, idx_next;
    logic              tail_done_reg, tail_done_next;
    logic              m_valid_reg, m_valid_next;

    // payload
    logic [CW-1:0]        tx_reg, ty_reg;
    logic signed [W-1:0]  dxs_reg, dys_reg;
    logic [CW-1:0]        prev_x_reg, prev_y_reg;
    logic                 prev_c_reg;
    logic [CW-1:0]        first_x_reg, first_y_reg;
    logic signed [W-1:0]  dxw_reg, dyw_reg, ox_reg, oy_reg;
    logic signed [PW-1:0] den_reg, na_reg;
    logic [FIELD_W-1:0]   id_reg;
    logic                 last_reg;
    logic                 see_reg;
    logic [FIELD_W-1:0]   m_id_reg;
    logic                 m_see_reg, m_ovf_reg, m_last_reg;

    // strobes
    logic        q_accept, first_load, prev_load, edge_load;
    logic        den_cap, na_cap, see_clr, m_load;
    logic        wr_en, rd_en;
    logic        accept;
    logic        blocks;
    logic        edge_to_first;
    musub_ctrl_t mctrl;

    logic [VW-1:0]        wr_data, rd_data;
    logic [CW-1:0]        rd_x, rd_y, b_x, b_y;
    logic                 rd_c;
    logic signed [PW-1:0] res;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign wr_data = {s_closes_polygon, s_vertex_y[CW-1:0], s_vertex_x[CW-1:0]};
    assign rd_x    = rd_data[CW-1:0];
    assign rd_y    = rd_data[2*CW-1:CW];
    assign rd_c    = rd_data[2*CW];

    lost_vstore #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW),
        .DW    (VW)
    ) u_vstore (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    lost_musub #(
        .W (W)
    ) u_musub (
        .aclk (aclk),
        .ctrl (mctrl),
        .dxs  (dxs_reg),
        .dys  (dys_reg),
        .dxw  (dxw_reg),
        .dyw  (dyw_reg),
        .ox   (ox_reg),
        .oy   (oy_reg),
        .res  (res)
    );

    // closing edge goes back to the polygon's first vertex
    assign edge_to_first = (state_reg == ST_TAIL) || prev_c_reg;
    assign b_x = edge_to_first ? first_x_reg : rd_x;
    assign b_y = edge_to_first ? first_y_reg : rd_y;

    assign blocks = (den_reg != '0) && in_unit(na_reg, den_reg) && in_unit(res, den_reg);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        tail_done_next = tail_done_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        q_accept       = 1'b0;
        first_load     = 1'b0;
        prev_load      = 1'b0;
        edge_load      = 1'b0;
        den_cap        = 1'b0;
        na_cap         = 1'b0;
        see_clr        = 1'b0;
        m_load         = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        mctrl.en       = 1'b0;
        mctrl.op       = OP_DEN;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_action)
                        ACT_CLEAR: begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        ACT_APPEND: begin
                            if (count_reg < CNTW'(MAX_VERTICES)) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        ACT_QUERY: begin
                            q_accept       = 1'b1;
                            idx_next       = '0;
                            tail_done_next = (count_reg == '0);
                            state_next     = (count_reg == '0) ? ST_DONE : ST_FETCH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                rd_en      = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                idx_next  = idx_reg + 1'b1;
                prev_load = 1'b1;
                if (idx_reg == '0) begin
                    first_load = 1'b1;
                    state_next = (CNTW'(1) < count_reg) ? ST_FETCH : ST_TAIL;
                end else begin
                    first_load = prev_c_reg;
                    edge_load  = 1'b1;
                    state_next = ST_E0;
                end
            end
            ST_TAIL: begin
                tail_done_next = 1'b1;
                edge_load      = 1'b1;
                state_next     = ST_E0;
            end
            ST_E0: begin
                mctrl.en   = 1'b1;
                mctrl.op   = OP_DEN;
                state_next = ST_E1;
            end
            ST_E1: begin
                mctrl.en   = 1'b1;
                mctrl.op   = OP_NA;
                den_cap    = 1'b1;
                state_next = ST_E2;
            end
            ST_E2: begin
                mctrl.en   = 1'b1;
                mctrl.op   = OP_NB;
                na_cap     = 1'b1;
                state_next = ST_E3;
            end
            ST_E3: begin
                if (blocks) begin
                    see_clr    = 1'b1;
                    state_next = ST_DONE;
                end else if (idx_reg < count_reg) begin
                    state_next = ST_FETCH;
                end else if (!tail_done_reg) begin
                    state_next = ST_TAIL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_load       = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            tail_done_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            tail_done_reg <= tail_done_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_accept) begin
            tx_reg   <= s_target_x[CW-1:0];
            ty_reg   <= s_target_y[CW-1:0];
            dxs_reg  <= sx(s_viewer_x[CW-1:0]) - sx(s_target_x[CW-1:0]);
            dys_reg  <= sx(s_viewer_y[CW-1:0]) - sx(s_target_y[CW-1:0]);
            id_reg   <= s_viewer_id;
            last_reg <= s_last_query;
            see_reg  <= 1'b1;
        end else if (see_clr) begin
            see_reg <= 1'b0;
        end
        if (edge_load) begin
            dxw_reg <= sx(b_x) - sx(prev_x_reg);
            dyw_reg <= sx(b_y) - sx(prev_y_reg);
            ox_reg  <= sx(tx_reg) - sx(prev_x_reg);
            oy_reg  <= sx(ty_reg) - sx(prev_y_reg);
        end
        if (first_load) begin
            first_x_reg <= rd_x;
            first_y_reg <= rd_y;
        end
        if (prev_load) begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
            prev_c_reg <= rd_c;
        end
        if (den_cap) begin
            den_reg <= res;
        end
        if (na_cap) begin
            na_reg <= res;
        end
        if (m_load) begin
            m_id_reg   <= id_reg;
            m_see_reg  <= see_reg;
            m_ovf_reg  <= ovf_reg;
            m_last_reg <= last_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_result_id        = m_id_reg;
    assign m_can_see          = m_see_reg;
    assign m_store_overflowed = m_ovf_reg;
    assign m_last_in_batch    = m_last_reg;

    // the walk index is stale between queries, a clear may drop the count below it
    `LOST_ASSERT_HOLD(a_idx_bound, aclk, aresetn, state_reg != ST_IDLE, idx_reg <= count_reg)
    `LOST_ASSERT_HOLD(a_ovf_when_full, aclk, aresetn, ovf_reg && !$past(ovf_reg), count_reg == CNTW'(MAX_VERTICES))
    `LOST_ASSERT_NEXT(a_query_busy, aclk, aresetn, accept && (s_action == ACT_QUERY), !s_ready)
    `LOST_ASSERT_NEXT(a_done_waits, aclk, aresetn, (state_reg == ST_DONE) && m_valid_reg && !m_ready, state_reg == ST_DONE)
endmodule
`default_nettype wire

@@ verif/line_of_sight_occlusion_test_test.sv @@
// Self-checking testbench for the line-of-sight occlusion test block.
`timescale 1ns / 100ps

module line_of_sight_occlusion_test_test;
    import lost_pkg::*;

    localparam int STORE_DEPTH = MAX_VERTICES_DEF;
    localparam int COORD_EFF = (COORD_WIDTH_DEF < 16) ? COORD_WIDTH_DEF : 16;
    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int SETTLE_CYCLES = 6 * STORE_DEPTH + 64;

    typedef struct {
        logic [1:0]  action;
        logic [15:0] vertex_x;
        logic [15:0] vertex_y;
        logic        closes;
        logic [15:0] viewer_id;
        logic [15:0] viewer_x;
        logic [15:0] viewer_y;
        logic [15:0] target_x;
        logic [15:0] target_y;
        logic        last_query;
    } los_word_t;

    typedef struct {
        logic [15:0] result_id;
        logic        can_see;
        logic        overflowed;
        logic        last_in_batch;
    } sight_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = ACT_CLEAR;
    logic [15:0] s_vertex_x = '0;
    logic [15:0] s_vertex_y = '0;
    logic        s_closes_polygon = 1'b0;
    logic [15:0] s_viewer_id = '0;
    logic [15:0] s_viewer_x = '0;
    logic [15:0] s_viewer_y = '0;
    logic [15:0] s_target_x = '0;
    logic [15:0] s_target_y = '0;
    logic        s_last_query = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_result_id;
    logic        m_can_see;
    logic        m_store_overflowed;
    logic        m_last_in_batch;

    // wall store as the block should hold it
    longint wall_x [STORE_DEPTH];
    longint wall_y [STORE_DEPTH];
    bit     wall_closes [STORE_DEPTH];
    int     wall_count = 0;
    bit     overflow_seen = 1'b0;

    sight_result_t pending_sight [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_sent = 0;
    int sights_checked = 0;
    int sights_blocked = 0;
    int dropped_vertices = 0;
    int mismatch_count = 0;
    int hold_len = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int cycles = 0;

    line_of_sight_occlusion_test #(
        .MAX_VERTICES (MAX_VERTICES_DEF),
        .COORD_WIDTH  (COORD_WIDTH_DEF)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_vertex_x         (s_vertex_x),
        .s_vertex_y         (s_vertex_y),
        .s_closes_polygon   (s_closes_polygon),
        .s_viewer_id        (s_viewer_id),
        .s_viewer_x         (s_viewer_x),
        .s_viewer_y         (s_viewer_y),
        .s_target_x         (s_target_x),
        .s_target_y         (s_target_y),
        .s_last_query       (s_last_query),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_id        (m_result_id),
        .m_can_see          (m_can_see),
        .m_store_overflowed (m_store_overflowed),
        .m_last_in_batch    (m_last_in_batch)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic longint to_coord(input logic [15:0] raw);
        logic signed [15:0] shifted;
        shifted = raw << (16 - COORD_EFF);
        return longint'(shifted >>> (16 - COORD_EFF));
    endfunction

    // num/den within [0,1], den nonzero
    function automatic bit frac_in_unit(input longint num, input longint den);
        if (den > 0)
            return num >= 0 && num <= den;
        return num <= 0 && num >= den;
    endfunction

    function automatic bit edge_occludes(input longint ax, input longint ay,
                                         input longint bx, input longint by,
                                         input longint vx, input longint vy,
                                         input longint tx, input longint ty);
        longint dxw, dyw, dxs, dys, ox, oy, den, na, nb;
        dxw = bx - ax;
        dyw = by - ay;
        dxs = vx - tx;
        dys = vy - ty;
        ox  = tx - ax;
        oy  = ty - ay;
        den = dyw * dxs - dxw * dys;
        if (den == 0)
            return 1'b0;
        na = dxw * oy - dyw * ox;
        nb = dxs * oy - dys * ox;
        return frac_in_unit(na, den) && frac_in_unit(nb, den);
    endfunction

    function automatic void predict_sight(input los_word_t w);
        sight_result_t r;
        longint vx, vy, tx, ty;
        bit see;
        int first;
        int j;
        case (w.action)
            ACT_CLEAR: begin
                wall_count = 0;
                overflow_seen = 1'b0;
            end
            ACT_APPEND: begin
                if (wall_count < STORE_DEPTH) begin
                    wall_x[wall_count] = to_coord(w.vertex_x);
                    wall_y[wall_count] = to_coord(w.vertex_y);
                    wall_closes[wall_count] = w.closes;
                    wall_count++;
                end else begin
                    overflow_seen = 1'b1;
                    dropped_vertices++;
                end
            end
            ACT_QUERY: begin
                vx = to_coord(w.viewer_x);
                vy = to_coord(w.viewer_y);
                tx = to_coord(w.target_x);
                ty = to_coord(w.target_y);
                see = 1'b1;
                first = 0;
                for (int i = 0; i < wall_count; i++) begin
                    // last edge of a polygon, closed or still open, wraps to its first vertex
                    j = (wall_closes[i] || i + 1 >= wall_count) ? first : i + 1;
                    if (edge_occludes(wall_x[i], wall_y[i], wall_x[j], wall_y[j],
                                      vx, vy, tx, ty)) begin
                        see = 1'b0;
                        break;
                    end
                    if (wall_closes[i])
                        first = i + 1;
                end
                r.result_id = w.viewer_id;
                r.can_see = see;
                r.overflowed = overflow_seen;
                r.last_in_batch = w.last_query;
                pending_sight.insert(pending_sight.size(), r);
            end
            default: ;
        endcase
    endfunction

    // ---------------- word builders ----------------

    function automatic los_word_t random_word();
        los_word_t w;
        w.action = 2'($urandom);
        w.vertex_x = 16'($urandom);
        w.vertex_y = 16'($urandom);
        w.closes = 1'($urandom);
        w.viewer_id = 16'($urandom);
        w.viewer_x = 16'($urandom);
        w.viewer_y = 16'($urandom);
        w.target_x = 16'($urandom);
        w.target_y = 16'($urandom);
        w.last_query = 1'($urandom);
        return w;
    endfunction

    function automatic los_word_t clear_word();
        los_word_t w;
        w = random_word();
        w.action = ACT_CLEAR;
        return w;
    endfunction

    function automatic los_word_t vertex_word(input int x, input int y, input bit c);
        los_word_t w;
        w = random_word();
        w.action = ACT_APPEND;
        w.vertex_x = 16'(x);
        w.vertex_y = 16'(y);
        w.closes = c;
        return w;
    endfunction

    function automatic los_word_t query_word(input int id, input int vx, input int vy,
                                             input int tx, input int ty, input bit last);
        los_word_t w;
        w = random_word();
        w.action = ACT_QUERY;
        w.viewer_id = 16'(id);
        w.viewer_x = 16'(vx);
        w.viewer_y = 16'(vy);
        w.target_x = 16'(tx);
        w.target_y = 16'(ty);
        w.last_query = last;
        return w;
    endfunction

    // mostly a small arena so sight lines meet walls often
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return 16'(int'($urandom_range(640)) - 320);
        endcase
    endfunction

    function automatic los_word_t random_query();
        los_word_t w;
        int k;
        w = query_word($urandom, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                       $urandom_range(1));
        // endpoint exactly on a stored vertex: the closed-interval case
        if (wall_count > 0 && $urandom_range(3) == 0) begin
            k = $urandom_range(wall_count - 1);
            w.target_x = 16'(wall_x[k]);
            w.target_y = 16'(wall_y[k]);
        end
        return w;
    endfunction

    // ---------------- driving ----------------

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input los_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= w.action;
        s_vertex_x <= w.vertex_x;
        s_vertex_y <= w.vertex_y;
        s_closes_polygon <= w.closes;
        s_viewer_id <= w.viewer_id;
        s_viewer_x <= w.viewer_x;
        s_viewer_y <= w.viewer_y;
        s_target_x <= w.target_x;
        s_target_y <= w.target_y;
        s_last_query <= w.last_query;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_sight(w);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_sight.size() != 0)
            @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------- checking ----------------

    always @(posedge aclk) begin
        sight_result_t exp;
        if (aresetn && m_valid && m_ready) begin
            if (pending_sight.size() == 0) begin
                $error("result word with no query pending: id %0h", m_result_id);
                mismatch_count++;
            end else begin
                exp = pending_sight.pop_front();
                sights_checked++;
                if (!exp.can_see)
                    sights_blocked++;
                if (m_result_id !== exp.result_id) begin
                    $error("result_id: expected %0h, got %0h", exp.result_id, m_result_id);
                    mismatch_count++;
                end
                if (m_can_see !== exp.can_see) begin
                    $error("can_see: expected %0b, got %0b", exp.can_see, m_can_see);
                    mismatch_count++;
                end
                if (m_store_overflowed !== exp.overflowed) begin
                    $error("store_overflowed: expected %0b, got %0b",
                           exp.overflowed, m_store_overflowed);
                    mismatch_count++;
                end
                if (m_last_in_batch !== exp.last_in_batch) begin
                    $error("last_in_batch: expected %0b, got %0b",
                           exp.last_in_batch, m_last_in_batch);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ---------------- tests ----------------

    task automatic test_directed_walls();
        send_idle_pct = 33;
        recv_idle_pct = 63;
        send_word(random_word() ); // any action, random payload
        begin
            los_word_t w;
            w = random_word();
            w.action = ACT_RESERVED;
            send_word(w);
        end
        // store holds at most the one random vertex, which never blocks, so both queries see
        send_word(query_word(0, -32768, -32768, 32767, 32767, 1'b0));
        send_word(query_word(16'hFFFF, 32767, 32767, -32768, -32768, 1'b1));
        send_word(clear_word());
        // closed square
        send_word(vertex_word(0, 0, 1'b0));
        send_word(vertex_word(160, 0, 1'b0));
        send_word(vertex_word(160, 160, 1'b0));
        send_word(vertex_word(0, 160, 1'b1));
        send_word(query_word(1, 80, -80, 80, 80, 1'b0));
        send_word(query_word(2, -80, -80, -80, 240, 1'b0));
        send_word(query_word(3, -160, 0, 0, 0, 1'b0));      // ends on a corner
        send_word(query_word(4, 80, -80, 80, 0, 1'b0));     // ends on an edge
        send_word(query_word(5, -80, 0, 320, 0, 1'b0));     // collinear with an edge
        send_word(query_word(6, 40, 40, 40, 40, 1'b1));     // zero-length sight
        // single-vertex polygon never blocks
        send_word(vertex_word(400, 400, 1'b1));
        send_word(query_word(7, 300, 400, 500, 400, 1'b0));
        // polygon left open: closing edge is implicit
        send_word(vertex_word(-400, -400, 1'b0));
        send_word(vertex_word(-200, -400, 1'b0));
        send_word(vertex_word(-200, -200, 1'b0));
        send_word(query_word(8, -350, -250, -250, -350, 1'b0));
        // full-scale wall and sight line
        send_word(vertex_word(-32768, -32768, 1'b0));
        send_word(vertex_word(32767, 32767, 1'b1));
        send_word(query_word(9, -32768, 32767, 32767, -32768, 1'b1));
        wait_results_drained();
    endtask

    task automatic test_store_overflow();
        send_idle_pct = 33;
        recv_idle_pct = 63;
        send_word(clear_word());
        for (int k = 0; k < STORE_DEPTH + 3; k++)
            send_word(vertex_word(pick_coord(), pick_coord(), (k % 4) == 3));
        send_word(random_query());
        send_word(clear_word());
        send_word(random_query());
        wait_results_drained();
    endtask

    // receiver stalls long enough for the output register to fill and block the input
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_word(clear_word());
        for (int k = 0; k < 6; k++)
            send_word(vertex_word(pick_coord(), pick_coord(), k == 5));
        hold_len = 400;
        hold_req++;
        repeat (12)
            send_word(random_query());
        wait_results_drained();
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct,
                                    input int budget);
        int stop_at;
        int nv;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = words_sent + budget;
        while (words_sent < stop_at) begin
            if ($urandom_range(99) < 15) begin
                send_word(random_word());
            end else begin
                if (wall_count > 40 || $urandom_range(1))
                    send_word(clear_word());
                repeat ($urandom_range(4)) begin
                    nv = $urandom_range(1, 6);
                    for (int k = 0; k < nv; k++)
                        send_word(vertex_word(pick_coord(), pick_coord(),
                                              k == nv - 1 && $urandom_range(3) != 0));
                end
                repeat ($urandom_range(1, 8))
                    send_word(random_query());
            end
        end
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        run_random_phase(33, 63, 185);
        run_random_phase(63, 33, 185);
        run_random_phase(0, 0, 185);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_walls();
        test_store_overflow();
        test_output_backpressure();
        test_random_traffic();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d words; checked %0d sight results, %0d of them occluded.",
                 words_sent, sights_checked, sights_blocked);
        $display("Store overflow dropped %0d vertices.", dropped_vertices);
        if (mismatch_count == 0 && pending_sight.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
